// File: hdl/pwc_pkg.sv
// pwc_pkg: shared constants, opcodes and pipeline tag type for the window capture block
`timescale 1ns / 1ps

package pwc_pkg;

    // default points per snapshot and fixed polyphase tap count
    localparam int SIZE_DEF   = 256;
    localparam int POLY_TAPS  = 8;
    localparam int BANK_W     = 3;

    // field widths
    localparam int OPCODE_W   = 2;
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 11;
    localparam int COEF_W     = 18;
    localparam int POINT_W    = 20;
    localparam int PNUM_W     = 8;
    localparam int RING_W     = 2 * SAMPLE_W;

    // window coefficients are Q1.17
    localparam int COEF_SHIFT = 17;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_LOAD     = 2'd1,
        OP_READ_WIN = 2'd2,
        OP_READ_RAW = 2'd3
    } op_t;

    // control that travels with a read through the datapath
    typedef struct packed {
        logic                 vld;
        logic                 raw;
        logic [BANK_W-1:0]    rot;
        logic [POLY_TAPS-1:0] mask;
        logic [PNUM_W-1:0]    pnum;
    } tag_t;

endpackage

// File: hdl/pwc_ifs.sv
// pwc_ifs: valid/ready channel interfaces for command beats and result beats
`timescale 1ns / 1ps

interface pwc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [pwc_pkg::OPCODE_W-1:0]    opcode;
    logic signed [pwc_pkg::SAMPLE_W-1:0]    sample_re;
    logic signed [pwc_pkg::SAMPLE_W-1:0]    sample_im;
    logic        [pwc_pkg::INDEX_W-1:0]     item_index;
    logic signed [pwc_pkg::COEF_W-1:0]      coef_value;

    modport source (output valid, opcode, sample_re, sample_im, item_index, coef_value,
                    input ready);
    modport sink   (input valid, opcode, sample_re, sample_im, item_index, coef_value,
                    output ready);
endinterface

interface pwc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pwc_pkg::POINT_W-1:0]     point_re;
    logic signed [pwc_pkg::POINT_W-1:0]     point_im;
    logic        [pwc_pkg::PNUM_W-1:0]      point_number;

    modport source (output valid, point_re, point_im, point_number, input ready);
    modport sink   (input valid, point_re, point_im, point_number, output ready);
endinterface

// File: hdl/pwc_ram.sv
// pwc_ram: one bank of simple dual-port memory with registered read data
`timescale 1ns / 1ps

module pwc_ram #(
    parameter int DEPTH = pwc_pkg::SIZE_DEF,
    parameter int WIDTH = pwc_pkg::RING_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pwc_mac.sv
// pwc_mac: tap rotation, complex weighting, adder tree, shift and saturation
`timescale 1ns / 1ps

module pwc_mac (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   adv,
    input  pwc_pkg::tag_t                                          tag,
    input  logic [pwc_pkg::POLY_TAPS-1:0][pwc_pkg::RING_W-1:0]     ring_rd,
    input  logic [pwc_pkg::POLY_TAPS-1:0][pwc_pkg::COEF_W-1:0]     win_rd,
    output logic                                                   out_vld,
    output logic signed [pwc_pkg::POINT_W-1:0]                     point_re,
    output logic signed [pwc_pkg::POINT_W-1:0]                     point_im,
    output logic [pwc_pkg::PNUM_W-1:0]                             point_number
);

    localparam int TAPS = pwc_pkg::POLY_TAPS;
    localparam int BW   = pwc_pkg::BANK_W;
    localparam int SW   = pwc_pkg::SAMPLE_W;
    localparam int OW   = pwc_pkg::POINT_W;
    localparam int PW   = SW + pwc_pkg::COEF_W;
    localparam int QW   = PW + 1;
    localparam int HW   = PW + 2;
    localparam int TW   = PW + 3;
    localparam logic signed [TW-1:0] OUT_MAX = TW'((1 <<< (OW - 1)) - 1);
    localparam logic signed [TW-1:0] OUT_MIN = -TW'(1 <<< (OW - 1));

    logic signed [PW-1:0] p_re_next [TAPS];
    logic signed [PW-1:0] p_im_next [TAPS];
    logic signed [PW-1:0] p_re_reg  [TAPS];
    logic signed [PW-1:0] p_im_reg  [TAPS];
    logic signed [QW-1:0] q_re_reg  [TAPS/2];
    logic signed [QW-1:0] q_im_reg  [TAPS/2];
    logic signed [HW-1:0] h_re_reg  [TAPS/4];
    logic signed [HW-1:0] h_im_reg  [TAPS/4];
    pwc_pkg::tag_t        tag2_reg;
    pwc_pkg::tag_t        tag3_reg;
    pwc_pkg::tag_t        tag4_reg;

    logic signed [TW-1:0] tot_re;
    logic signed [TW-1:0] tot_im;
    logic signed [TW-1:0] sh_re;
    logic signed [TW-1:0] sh_im;
    logic signed [OW-1:0] sat_re;
    logic signed [OW-1:0] sat_im;

    logic                 out_vld_reg;
    logic signed [OW-1:0] point_re_reg;
    logic signed [OW-1:0] point_im_reg;
    logic [pwc_pkg::PNUM_W-1:0] point_number_reg;

    // rotate ring banks onto taps, mask unused or unwritten entries, weight each tap (raw reads scale the sample up)
    always_comb
    begin
        logic [BW-1:0]        src;
        logic signed [SW-1:0] s_re;
        logic signed [SW-1:0] s_im;
        logic signed [pwc_pkg::COEF_W-1:0] w;
        for (int k = 0; k < TAPS; k++)
        begin
            src  = tag.rot + BW'(k);
            s_re = ring_rd[src][pwc_pkg::RING_W-1:SW];
            s_im = ring_rd[src][SW-1:0];
            w    = win_rd[k];
            if (!tag.mask[k])
            begin
                p_re_next[k] = '0;
                p_im_next[k] = '0;
            end
            else if (tag.raw)
            begin
                p_re_next[k] = PW'(s_re) <<< pwc_pkg::COEF_SHIFT;
                p_im_next[k] = PW'(s_im) <<< pwc_pkg::COEF_SHIFT;
            end
            else
            begin
                p_re_next[k] = PW'(s_re) * PW'(w);
                p_im_next[k] = PW'(s_im) * PW'(w);
            end
        end
    end

    // product registers and first two adder levels
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                p_re_reg[k] <= p_re_next[k];
                p_im_reg[k] <= p_im_next[k];
            end
            for (int k = 0; k < TAPS / 2; k++)
            begin
                q_re_reg[k] <= QW'(p_re_reg[2*k]) + QW'(p_re_reg[2*k+1]);
                q_im_reg[k] <= QW'(p_im_reg[2*k]) + QW'(p_im_reg[2*k+1]);
            end
            for (int k = 0; k < TAPS / 4; k++)
            begin
                h_re_reg[k] <= HW'(q_re_reg[2*k]) + HW'(q_re_reg[2*k+1]);
                h_im_reg[k] <= HW'(q_im_reg[2*k]) + HW'(q_im_reg[2*k+1]);
            end
        end
    end

    // tag travels alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else if (adv)
        begin
            tag2_reg <= tag;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // last adder level, arithmetic shift and saturation
    always_comb
    begin
        tot_re = TW'(h_re_reg[0]) + TW'(h_re_reg[1]);
        tot_im = TW'(h_im_reg[0]) + TW'(h_im_reg[1]);
        sh_re  = tot_re >>> pwc_pkg::COEF_SHIFT;
        sh_im  = tot_im >>> pwc_pkg::COEF_SHIFT;
        if (sh_re > OUT_MAX)
        begin
            sat_re = OUT_MAX[OW-1:0];
        end
        else if (sh_re < OUT_MIN)
        begin
            sat_re = OUT_MIN[OW-1:0];
        end
        else
        begin
            sat_re = sh_re[OW-1:0];
        end
        if (sh_im > OUT_MAX)
        begin
            sat_im = OUT_MAX[OW-1:0];
        end
        else if (sh_im < OUT_MIN)
        begin
            sat_im = OUT_MIN[OW-1:0];
        end
        else
        begin
            sat_im = sh_im[OW-1:0];
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= tag4_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            point_re_reg     <= sat_re;
            point_im_reg     <= sat_im;
            point_number_reg <= tag4_reg.pnum;
        end
    end

    assign out_vld      = out_vld_reg;
    assign point_re     = point_re_reg;
    assign point_im     = point_im_reg;
    assign point_number = point_number_reg;

endmodule

// File: hdl/polyphase_window_capture.sv
// polyphase_window_capture: banked sample ring and window table with windowed snapshot reads
`timescale 1ns / 1ps

// Complex samples are pushed into a ring of SIZE entries (8*SIZE in polyphase mode)
// held in eight memory banks of SIZE words; the window table is banked the same way,
// so all eight taps of a polyphase read come out of one memory access. The block takes
// one command beat per cycle as long as result beats are taken; a read gives its result
// beat through registered steps (memory read, multiply, three adder levels with shift
// and saturation), and a stalled output holds the whole pipeline. Pushes and
// coefficient loads write the banks in the cycle they are accepted and give no result;
// reads at a point of SIZE or above give none either. After reset the window table is
// cleared in a pass, one row of all eight banks per cycle, while in_ch.ready stays low.
// Changing the mode (cfg_we with a new cfg_wdata) empties the ring and restarts the
// write pointer; ring entries not yet written since then read as zero.

module polyphase_window_capture #(
    parameter int SIZE = pwc_pkg::SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    pwc_in_if.sink           in_ch,
    pwc_out_if.source        out_ch
);

    localparam int TAPS     = pwc_pkg::POLY_TAPS;
    localparam int BW       = pwc_pkg::BANK_W;
    localparam int AW       = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int XW       = 17;
    localparam int RING_LEN = TAPS * SIZE;

    // control state
    logic          mode_reg;
    logic [AW-1:0] wp_addr_reg;
    logic [BW-1:0] wp_bank_reg;
    logic          full_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    pwc_pkg::tag_t s1_tag_reg;
    pwc_pkg::tag_t s1_tag_next;

    // handshake and decode
    logic          adv;
    logic          out_vld;
    logic          acc;
    pwc_pkg::op_t  op;
    logic          is_push;
    logic          is_load;
    logic          is_rd;
    logic [XW-1:0] idx_w;
    logic [XW-1:0] sum_w;
    logic [XW-1:0] j_w;
    logic          wrap;
    logic [AW-1:0] j_addr;
    logic [BW-1:0] bj;
    logic [BW-1:0] ld_bank;
    logic [XW-1:0] ld_base;
    logic [XW-1:0] ld_off;
    logic          ld_ok;

    // bank ports
    logic [TAPS-1:0]                             ring_we;
    logic [TAPS-1:0]                             win_we;
    logic [AW-1:0]                               win_waddr;
    logic [pwc_pkg::COEF_W-1:0]                  win_wdata;
    logic [pwc_pkg::RING_W-1:0]                  ring_wdata;
    logic [TAPS-1:0][pwc_pkg::RING_W-1:0]        ring_rd;
    logic [TAPS-1:0][pwc_pkg::COEF_W-1:0]        win_rd;

    assign adv          = !out_vld || out_ch.ready;
    assign in_ch.ready  = adv && !clr_busy_reg;
    assign acc          = in_ch.valid && in_ch.ready;
    assign op           = pwc_pkg::op_t'(in_ch.opcode);
    assign idx_w        = XW'(in_ch.item_index);

    // command decode and oldest-sample address
    always_comb
    begin
        is_push = acc && (op == pwc_pkg::OP_PUSH);
        is_load = acc && (op == pwc_pkg::OP_LOAD);
        is_rd   = acc && ((op == pwc_pkg::OP_READ_WIN) || (op == pwc_pkg::OP_READ_RAW))
                  && (idx_w < XW'(SIZE));
        sum_w   = XW'(wp_addr_reg) + idx_w;
        wrap    = (sum_w >= XW'(SIZE));
        j_w     = wrap ? (sum_w - XW'(SIZE)) : sum_w;
        j_addr  = j_w[AW-1:0];
        bj      = mode_reg ? (wp_bank_reg + BW'(wrap)) : '0;
    end

    // per-tap enable: tap in use and ring entry written since the last clear
    always_comb
    begin
        logic [BW-1:0] bank_k;
        logic          used;
        logic          written;
        s1_tag_next      = '0;
        s1_tag_next.vld  = is_rd;
        s1_tag_next.raw  = (op == pwc_pkg::OP_READ_RAW);
        s1_tag_next.rot  = bj;
        s1_tag_next.pnum = in_ch.item_index[pwc_pkg::PNUM_W-1:0];
        for (int k = 0; k < TAPS; k++)
        begin
            bank_k  = bj + BW'(k);
            used    = (k == 0) || (mode_reg && (op == pwc_pkg::OP_READ_WIN));
            written = full_reg || (bank_k < wp_bank_reg)
                      || ((bank_k == wp_bank_reg) && (j_addr < wp_addr_reg));
            s1_tag_next.mask[k] = used && written;
        end
    end

    // coefficient load: split index into bank and row
    always_comb
    begin
        ld_bank = '0;
        ld_base = '0;
        for (int k = 1; k < TAPS; k++)
        begin
            if (idx_w >= XW'(k * SIZE))
            begin
                ld_bank = BW'(k);
                ld_base = XW'(k * SIZE);
            end
        end
        ld_off = idx_w - ld_base;
        ld_ok  = (idx_w < XW'(RING_LEN));
    end

    // bank write controls
    always_comb
    begin
        ring_wdata = {in_ch.sample_re, in_ch.sample_im};
        win_waddr  = clr_busy_reg ? clr_addr_reg : ld_off[AW-1:0];
        win_wdata  = clr_busy_reg ? '0 : in_ch.coef_value;
        for (int b = 0; b < TAPS; b++)
        begin
            ring_we[b] = is_push && (wp_bank_reg == BW'(b));
            win_we[b]  = clr_busy_reg || (is_load && ld_ok && (ld_bank == BW'(b)));
        end
    end

    // mode register and write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            wp_addr_reg <= '0;
            wp_bank_reg <= '0;
            full_reg    <= 1'b0;
        end
        else if (cfg_we && (cfg_wdata != mode_reg))
        begin
            mode_reg    <= cfg_wdata;
            wp_addr_reg <= '0;
            wp_bank_reg <= '0;
            full_reg    <= 1'b0;
        end
        else if (is_push)
        begin
            if (wp_addr_reg == AW'(SIZE - 1))
            begin
                wp_addr_reg <= '0;
                if (mode_reg)
                begin
                    wp_bank_reg <= wp_bank_reg + BW'(1);
                    if (wp_bank_reg == BW'(TAPS - 1))
                    begin
                        full_reg <= 1'b1;
                    end
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end
            else
            begin
                wp_addr_reg <= wp_addr_reg + AW'(1);
            end
        end
    end

    // window table clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(SIZE - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // read tag waits alongside the memory access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= s1_tag_next;
        end
    end

    // eight ring banks and eight window banks
    for (genvar b = 0; b < TAPS; b++)
    begin : g_bank
        pwc_ram #(
            .DEPTH (SIZE),
            .WIDTH (pwc_pkg::RING_W),
            .AW    (AW)
        ) u_ring (
            .clk   (clk),
            .we    (ring_we[b]),
            .waddr (wp_addr_reg),
            .wdata (ring_wdata),
            .re    (is_rd),
            .raddr (j_addr),
            .rdata (ring_rd[b])
        );

        pwc_ram #(
            .DEPTH (SIZE),
            .WIDTH (pwc_pkg::COEF_W),
            .AW    (AW)
        ) u_win (
            .clk   (clk),
            .we    (win_we[b]),
            .waddr (win_waddr),
            .wdata (win_wdata),
            .re    (is_rd),
            .raddr (idx_w[AW-1:0]),
            .rdata (win_rd[b])
        );
    end

    // weighting datapath and output register
    pwc_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .tag          (s1_tag_reg),
        .ring_rd      (ring_rd),
        .win_rd       (win_rd),
        .out_vld      (out_vld),
        .point_re     (out_ch.point_re),
        .point_im     (out_ch.point_im),
        .point_number (out_ch.point_number)
    );

    assign out_ch.valid = out_vld;

endmodule

// File: bench/polyphase_window_capture_tb.sv
// polyphase_window_capture_tb: self-checking bench for the window capture block
`timescale 1ns / 1ps

module polyphase_window_capture_tb;

    localparam int PTS         = pwc_pkg::SIZE_DEF;
    localparam int RING_PTS    = pwc_pkg::POLY_TAPS * pwc_pkg::SIZE_DEF;
    localparam int SMP_W       = pwc_pkg::SAMPLE_W;
    localparam int IDX_W       = pwc_pkg::INDEX_W;
    localparam int CF_W        = pwc_pkg::COEF_W;
    localparam int PT_W        = pwc_pkg::POINT_W;
    localparam int NUM_W       = pwc_pkg::PNUM_W;
    localparam int DRAIN       = 12;
    localparam int HOLD_CYCLES = 200;
    localparam int WD_LIMIT    = 4000;

    typedef struct {
        pwc_pkg::op_t              op;
        logic signed [SMP_W-1:0]   re;
        logic signed [SMP_W-1:0]   im;
        logic        [IDX_W-1:0]   idx;
        logic signed [CF_W-1:0]    coef;
    } cmd_t;

    typedef struct {
        logic signed [PT_W-1:0]    re;
        logic signed [PT_W-1:0]    im;
        logic        [NUM_W-1:0]   num;
    } point_t;

    // how a directed row is checked
    typedef enum int {
        CHK_MODEL,
        CHK_TYPED,
        CHK_NONE
    } chk_t;

    typedef struct {
        bit                        set_mode;
        bit                        mode_val;
        cmd_t                      c;
        chk_t                      chk;
        logic signed [PT_W-1:0]    e_re;
        logic signed [PT_W-1:0]    e_im;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pwc_in_if  in_ch ();
    pwc_out_if out_ch ();

    polyphase_window_capture #(
        .SIZE (PTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow state of the capture ring and window table
    logic signed [SMP_W-1:0] ring_re [RING_PTS];
    logic signed [SMP_W-1:0] ring_im [RING_PTS];
    logic signed [CF_W-1:0]  win_tab [RING_PTS];
    int unsigned             wr_ptr;
    bit                      poly_on;

    point_t pending_points [$];

    int  errors;
    int  cmds_sent;
    int  points_checked;
    int  mode_writes;
    int  quiet_cycles;
    bit  idle_on;
    bit  hold_req;
    bit  hold_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // clamp a shifted sum to the 20-bit point range
    function automatic logic signed [PT_W-1:0] clip20(input longint v);
        if (v > 524287)
            return PT_W'(524287);
        if (v < -524288)
            return PT_W'(-524288);
        return PT_W'(v);
    endfunction

    // apply one command to the shadow state, return 1 with the point a read gives
    function automatic bit predict_point(input cmd_t c, output point_t p);
        int unsigned len;
        int unsigned j;
        int unsigned a;
        int unsigned taps;
        longint      acc_re;
        longint      acc_im;
        len   = poly_on ? RING_PTS : PTS;
        p.re  = '0;
        p.im  = '0;
        p.num = '0;
        if (c.op == pwc_pkg::OP_PUSH)
        begin
            ring_re[wr_ptr % len] = c.re;
            ring_im[wr_ptr % len] = c.im;
            wr_ptr = (wr_ptr % len + 1) % len;
            return 1'b0;
        end
        if (c.op == pwc_pkg::OP_LOAD)
        begin
            if (c.idx < RING_PTS)
                win_tab[c.idx] = c.coef;
            return 1'b0;
        end
        if (c.idx >= PTS)
            return 1'b0;
        j = (wr_ptr + c.idx) % len;
        if (c.op == pwc_pkg::OP_READ_RAW)
        begin
            acc_re = longint'(ring_re[j]);
            acc_im = longint'(ring_im[j]);
        end
        else
        begin
            acc_re = 0;
            acc_im = 0;
            taps   = poly_on ? pwc_pkg::POLY_TAPS : 1;
            for (int unsigned k = 0; k < taps; k++)
            begin
                a = (j + k * PTS) % len;
                acc_re += longint'(ring_re[a]) * longint'(win_tab[c.idx + k * PTS]);
                acc_im += longint'(ring_im[a]) * longint'(win_tab[c.idx + k * PTS]);
            end
            acc_re = acc_re >>> pwc_pkg::COEF_SHIFT;
            acc_im = acc_im >>> pwc_pkg::COEF_SHIFT;
        end
        p.re  = clip20(acc_re);
        p.im  = clip20(acc_im);
        p.num = c.idx[NUM_W-1:0];
        return 1'b1;
    endfunction

    // sample value with extra weight on the extremes
    function automatic logic signed [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return SMP_W'(-32768);
            1: return SMP_W'(32767);
            2: return '0;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic cmd_t rand_cmd(input int push_pct);
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            c.op = pwc_pkg::OP_PUSH;
        else
        begin
            r = $urandom_range(0, 9);
            c.op = (r < 3) ? pwc_pkg::OP_LOAD :
                   ((r < 8) ? pwc_pkg::OP_READ_WIN : pwc_pkg::OP_READ_RAW);
        end
        c.re = rand_sample();
        c.im = rand_sample();
        case ($urandom_range(0, 15))
            0: c.coef = CF_W'(-131072);
            1: c.coef = CF_W'(131071);
            default: c.coef = CF_W'($urandom);
        endcase
        if (c.op == pwc_pkg::OP_LOAD)
            c.idx = IDX_W'($urandom_range(0, RING_PTS - 1));
        else if ($urandom_range(0, 9) == 0)
            c.idx = IDX_W'($urandom_range(PTS, (1 << IDX_W) - 1));
        else
            c.idx = IDX_W'($urandom_range(0, PTS - 1));
        return c;
    endfunction

    function automatic row_t cmd_row(input pwc_pkg::op_t op, input int re, input int im,
                                     input int idx, input int coef, input chk_t chk,
                                     input int e_re, input int e_im);
        row_t r;
        r.set_mode = 1'b0;
        r.mode_val = 1'b0;
        r.c.op     = op;
        r.c.re     = SMP_W'(re);
        r.c.im     = SMP_W'(im);
        r.c.idx    = IDX_W'(idx);
        r.c.coef   = CF_W'(coef);
        r.chk      = chk;
        r.e_re     = PT_W'(e_re);
        r.e_im     = PT_W'(e_im);
        return r;
    endfunction

    function automatic row_t mode_row(input bit m);
        row_t r;
        r = cmd_row(pwc_pkg::OP_PUSH, 0, 0, 0, 0, CHK_NONE, 0, 0);
        r.set_mode = 1'b1;
        r.mode_val = m;
        return r;
    endfunction

    // offer one command beat, optionally after a gap, and log its expected point
    task automatic send_beat(input cmd_t c, input chk_t chk,
                             input logic signed [PT_W-1:0] e_re,
                             input logic signed [PT_W-1:0] e_im);
        point_t p;
        bit     yields;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= c.op;
        in_ch.sample_re  <= c.re;
        in_ch.sample_im  <= c.im;
        in_ch.item_index <= c.idx;
        in_ch.coef_value <= c.coef;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        cmds_sent++;
        yields = predict_point(c, p);
        if (chk == CHK_TYPED)
        begin
            yields = 1'b1;
            p.re   = e_re;
            p.im   = e_im;
            p.num  = c.idx[NUM_W-1:0];
        end
        else if (chk == CHK_NONE)
            yields = 1'b0;
        if (yields)
            pending_points.push_back(p);
    endtask

    // stop offering and let every outstanding read come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_writes++;
        // a real change empties the ring and restarts the pointer
        if (m != poly_on)
        begin
            poly_on = m;
            wr_ptr  = 0;
            for (int i = 0; i < RING_PTS; i++)
            begin
                ring_re[i] = '0;
                ring_im[i] = '0;
            end
        end
    endtask

    task automatic run_phase(input bit m, input int n, input int push_pct, input bit with_idle);
        write_mode(m);
        idle_on = with_idle;
        for (int i = 0; i < n; i++)
        begin
            if (!hold_done && i == 30)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_beat(rand_cmd(push_pct), CHK_MODEL, '0, '0);
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each result beat with the oldest expected point
    always @(posedge clk)
    begin : check_beat
        point_t exp_pt;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point re=%0d im=%0d num=%0d", $realtime,
                         out_ch.point_re, out_ch.point_im, out_ch.point_number);
                errors++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (out_ch.point_re !== exp_pt.re)
                begin
                    $display("%0t: point_re expected %0d actual %0d", $realtime, exp_pt.re,
                             out_ch.point_re);
                    errors++;
                end
                if (out_ch.point_im !== exp_pt.im)
                begin
                    $display("%0t: point_im expected %0d actual %0d", $realtime, exp_pt.im,
                             out_ch.point_im);
                    errors++;
                end
                if (out_ch.point_number !== exp_pt.num)
                begin
                    $display("%0t: point_number expected %0d actual %0d", $realtime,
                             exp_pt.num, out_ch.point_number);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WD_LIMIT)
        begin
            $display("%0t: timeout, no beat for %0d cycles", $realtime, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        row_t rows [$];
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= pwc_pkg::OP_PUSH;
        in_ch.sample_re  <= '0;
        in_ch.sample_im  <= '0;
        in_ch.item_index <= '0;
        in_ch.coef_value <= '0;
        errors         = 0;
        cmds_sent      = 0;
        points_checked = 0;
        mode_writes    = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        poly_on        = 1'b0;
        wr_ptr         = 0;
        for (int i = 0; i < RING_PTS; i++)
        begin
            ring_re[i] = '0;
            ring_im[i] = '0;
            win_tab[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: empty ring, range limits, extremes, rounding, mode changes
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 0, 0, CHK_TYPED, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 255, 0, CHK_TYPED, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 256, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 2047, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_LOAD, 0, 0, 255, -131072, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_LOAD, 0, 0, 0, 131071, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_LOAD, 0, 0, 2047, 131071, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_PUSH, -32768, 32767, 0, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 255, 0, CHK_TYPED, -32768, 32767));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 255, 0, CHK_TYPED, 32768, -32767));
        rows.push_back(cmd_row(pwc_pkg::OP_PUSH, 1, -1, 0, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_LOAD, 0, 0, 255, 1, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 255, 0, CHK_TYPED, 0, -1));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 0, 0, CHK_MODEL, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_PUSH, 32767, -32768, 0, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 254, 0, CHK_MODEL, 0, 0));
        rows.push_back(mode_row(1'b1));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 0, 0, CHK_TYPED, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_PUSH, -32768, -32768, 0, 0, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_LOAD, 0, 0, 1792, -131072, CHK_NONE, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 0, 0, CHK_MODEL, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_WIN, 0, 0, 255, 0, CHK_MODEL, 0, 0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 2047, 0, CHK_NONE, 0, 0));
        rows.push_back(mode_row(1'b0));
        rows.push_back(cmd_row(pwc_pkg::OP_READ_RAW, 0, 0, 100, 0, CHK_TYPED, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].set_mode)
                write_mode(rows[i].mode_val);
            else
                send_beat(rows[i].c, rows[i].chk, rows[i].e_re, rows[i].e_im);
        end

        // random phases; the push-heavy one walks the pointer past the end of the first bank
        run_phase(1'b0, 110, 35, 1'b1);
        run_phase(1'b1, 60, 35, 1'b0);
        run_phase(1'b1, 380, 90, 1'b1);
        run_phase(1'b0, 90, 35, 1'b1);
        run_phase(1'b1, 80, 35, 1'b1);
        run_phase(1'b0, 57, 35, 1'b0);

        settle();
        $display("covered %0d commands over both modes with %0d mode writes", cmds_sent,
                 mode_writes);
        $display("compared %0d points, %0d mismatches", points_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
